[rtl/core/sha1_pkg.sv]
// Shared types, constants and helper functions of the SHA-1 hash engine.
package sha1_pkg;

    // Round constants, one per group of twenty rounds
    localparam logic [31:0] K_CH     = 32'h5a82_7999;
    localparam logic [31:0] K_PARITY = 32'h6ed9_eba1;
    localparam logic [31:0] K_MAJ    = 32'h8f1b_bcdc;
    localparam logic [31:0] K_PAR2   = 32'hca62_c1d6;

    // Initial chain value H0..H4
    localparam logic [31:0] H_INIT [5] = '{
        32'h6745_2301, 32'hefcd_ab89, 32'h98ba_dcfe, 32'h1032_5476, 32'hc3d2_e1f0
    };

    // Padding marker word: 0x80 byte followed by zeros
    localparam logic [31:0] PAD_MARK_WORD = 32'h8000_0000;

    localparam int unsigned WORD_W   = 32;
    localparam int unsigned NB_W     = 3;
    localparam int unsigned COUNT_W  = 61;
    localparam int unsigned WPOS_W   = 4;
    localparam int unsigned ROUND_W  = 7;
    localparam int unsigned OIDX_W   = 3;
    localparam int unsigned S_DATA_W = 40;

    localparam logic [ROUND_W-1:0] LAST_ROUND  = 7'd79;
    localparam logic [OIDX_W-1:0]  LAST_DIGEST = 3'd4;
    localparam logic [NB_W-1:0]    FULL_NB     = 3'd4;

    // What gets shifted into the schedule window
    typedef enum logic [2:0] {
        SEL_INPUT,
        SEL_MARK,
        SEL_ZERO,
        SEL_LEN_HI,
        SEL_LEN_LO,
        SEL_SCHED
    } sha1_shift_sel_t;

    // Round function group
    typedef enum logic [1:0] {
        PH_CH,
        PH_PARITY,
        PH_MAJ,
        PH_PAR2
    } sha1_phase_t;

    // Controller to datapath commands
    typedef struct packed {
        logic                 shift_en;
        sha1_shift_sel_t      shift_sel;
        logic                 count_en;
        logic                 load_work;
        logic                 round_en;
        sha1_phase_t          phase;
        logic                 chain_add;
        logic                 msg_clear;
        logic [OIDX_W-1:0]    out_idx;
    } sha1_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic wpos_last;   // next word completes the block
        logic wpos_len;    // next word is the length high word slot
        logic full_word;   // current input word has four valid bytes
    } sha1_status_t;

    // Valid byte count with out-of-range codes treated as four
    function automatic logic [NB_W-1:0] clamp_nb(input logic [NB_W-1:0] vb);
        logic [NB_W-1:0] nb;
        nb = (vb inside {[3'd5:3'd7]}) ? FULL_NB : vb;
        return nb;
    endfunction

    // Final message word, with the 0x80 marker appended after the valid bytes when fewer than four are valid
    function automatic logic [WORD_W-1:0] pad_word(input logic [WORD_W-1:0] data,
                                                   input logic [NB_W-1:0]   nb);
        logic [WORD_W-1:0] w;
        case (nb)
            3'd0:    w = PAD_MARK_WORD;
            3'd1:    w = {data[31:24], 8'h80, 16'h0000};
            3'd2:    w = {data[31:16], 8'h80, 8'h00};
            3'd3:    w = {data[31:8], 8'h80};
            default: w = data;
        endcase
        return w;
    endfunction

endpackage

[rtl/core/sha1_dpath.sv]
// SHA-1 datapath: schedule window, round unit, chain value and byte count.
module sha1_dpath
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sha1_pkg::sha1_cmd_t         cmd,
    output sha1_pkg::sha1_status_t      status,
    input  logic [31:0]                 data_word,
    input  logic [2:0]                  valid_bytes,
    input  logic                        last,
    output logic [31:0]                 digest_word
);
    import sha1_pkg::*;

    logic [WORD_W-1:0]  sched_reg [16];
    logic [WORD_W-1:0]  work_reg  [5];
    logic [WORD_W-1:0]  chain_reg [5];
    logic [COUNT_W-1:0] count_reg;
    logic [WPOS_W-1:0]  wpos_reg;

    logic [NB_W-1:0]    nb;
    logic [WORD_W-1:0]  in_word;
    logic [WORD_W-1:0]  sched_new;
    logic [WORD_W-1:0]  shift_word;
    logic [WORD_W-1:0]  f_val;
    logic [WORD_W-1:0]  k_val;
    logic [WORD_W-1:0]  t_val;
    logic [WORD_W-1:0]  mix;
    logic [COUNT_W-1:0] count_inc;

    // Input word and its byte count
    assign nb        = clamp_nb(valid_bytes);
    assign in_word   = last ? pad_word(data_word, nb) : data_word;
    assign count_inc = last ? COUNT_W'(nb) : COUNT_W'(FULL_NB);

    // Message schedule recurrence over the window
    assign mix       = sched_reg[13] ^ sched_reg[8] ^ sched_reg[2] ^ sched_reg[0];
    assign sched_new = {mix[30:0], mix[31]};

    always_comb
    begin
        case (cmd.shift_sel)
            SEL_INPUT:  shift_word = in_word;
            SEL_MARK:   shift_word = PAD_MARK_WORD;
            SEL_ZERO:   shift_word = '0;
            SEL_LEN_HI: shift_word = count_reg[60:29];
            SEL_LEN_LO: shift_word = {count_reg[28:0], 3'b000};
            SEL_SCHED:  shift_word = sched_new;
            default:    shift_word = '0;
        endcase
    end

    // Round function and constant
    always_comb
    begin
        case (cmd.phase)
            PH_CH:
            begin
                f_val = (work_reg[1] & work_reg[2]) | (~work_reg[1] & work_reg[3]);
                k_val = K_CH;
            end
            PH_PARITY:
            begin
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k_val = K_PARITY;
            end
            PH_MAJ:
            begin
                f_val = (work_reg[1] & work_reg[2]) | (work_reg[1] & work_reg[3]) |
                        (work_reg[2] & work_reg[3]);
                k_val = K_MAJ;
            end
            default:
            begin
                f_val = work_reg[1] ^ work_reg[2] ^ work_reg[3];
                k_val = K_PAR2;
            end
        endcase
    end

    assign t_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4] +
                   k_val + sched_reg[0];

    // Schedule window: sixteen-word shift line, no reset
    always_ff @(posedge clk)
    begin
        if (cmd.shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                sched_reg[i] <= sched_reg[i+1];
            end
            sched_reg[15] <= shift_word;
        end
    end

    // Working variables a..e
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                work_reg[i] <= '0;
            end
        end
        else if (cmd.load_work)
        begin
            for (int i = 0; i < 5; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (cmd.round_en)
        begin
            work_reg[0] <= t_val;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

    // Chain value, byte count and word position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= H_INIT[i];
            end
            count_reg <= '0;
            wpos_reg  <= '0;
        end
        else
        begin
            if (cmd.msg_clear)
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_reg[i] <= H_INIT[i];
                end
                count_reg <= '0;
                wpos_reg  <= '0;
            end
            else
            begin
                if (cmd.chain_add)
                begin
                    for (int i = 0; i < 5; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
                if (cmd.count_en)
                begin
                    count_reg <= count_reg + count_inc;
                end
                if (cmd.shift_en && (cmd.shift_sel != SEL_SCHED))
                begin
                    wpos_reg <= wpos_reg + 4'd1;
                end
            end
        end
    end

    // Status back to the controller
    assign status.wpos_last = (wpos_reg == 4'd15);
    assign status.wpos_len  = (wpos_reg == 4'd14);
    assign status.full_word = (nb == FULL_NB);

    // Digest word select
    always_comb
    begin
        case (cmd.out_idx)
            3'd0:    digest_word = chain_reg[0];
            3'd1:    digest_word = chain_reg[1];
            3'd2:    digest_word = chain_reg[2];
            3'd3:    digest_word = chain_reg[3];
            default: digest_word = chain_reg[4];
        endcase
    end

endmodule

[rtl/core/sha1_ctrl.sv]
// SHA-1 controller: input, padding, round sequencing and digest output.
module sha1_ctrl
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_last,
    output logic                        in_ready,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        out_last,
    output sha1_pkg::sha1_cmd_t         cmd,
    input  sha1_pkg::sha1_status_t      status
);
    import sha1_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_LEN_LO,
        ST_ROUND,
        ST_FIN,
        ST_OUT
    } state_t;

    state_t             state_reg, state_next;
    state_t             ret_reg, ret_next;
    logic [ROUND_W-1:0] round_reg, round_next;
    logic               mark_reg, mark_next;
    logic [OIDX_W-1:0]  oidx_reg, oidx_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        round_next = round_reg;
        mark_next  = mark_reg;
        oidx_next  = oidx_reg;
        cmd        = '0;
        cmd.out_idx = oidx_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.shift_en  = 1'b1;
                    cmd.shift_sel = SEL_INPUT;
                    cmd.count_en  = 1'b1;
                    if (in_last)
                    begin
                        mark_next  = status.full_word;
                        state_next = ST_PAD;
                    end
                    if (status.wpos_last)
                    begin
                        cmd.load_work = 1'b1;
                        round_next    = '0;
                        ret_next      = in_last ? ST_PAD : ST_IDLE;
                        state_next    = ST_ROUND;
                    end
                end
            end
            ST_PAD:
            begin
                cmd.shift_en = 1'b1;
                if (mark_reg)
                begin
                    cmd.shift_sel = SEL_MARK;
                    mark_next     = 1'b0;
                end
                else if (status.wpos_len)
                begin
                    cmd.shift_sel = SEL_LEN_HI;
                    state_next    = ST_LEN_LO;
                end
                else
                begin
                    cmd.shift_sel = SEL_ZERO;
                end
                if (status.wpos_last)
                begin
                    cmd.load_work = 1'b1;
                    round_next    = '0;
                    ret_next      = ST_PAD;
                    state_next    = ST_ROUND;
                end
            end
            ST_LEN_LO:
            begin
                cmd.shift_en  = 1'b1;
                cmd.shift_sel = SEL_LEN_LO;
                cmd.load_work = 1'b1;
                round_next    = '0;
                ret_next      = ST_OUT;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.shift_en  = 1'b1;
                cmd.shift_sel = SEL_SCHED;
                cmd.round_en  = 1'b1;
                if (round_reg < 7'd20)
                begin
                    cmd.phase = PH_CH;
                end
                else if (round_reg < 7'd40)
                begin
                    cmd.phase = PH_PARITY;
                end
                else if (round_reg < 7'd60)
                begin
                    cmd.phase = PH_MAJ;
                end
                else
                begin
                    cmd.phase = PH_PAR2;
                end
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                begin
                    round_next = '0;
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                cmd.chain_add = 1'b1;
                oidx_next     = '0;
                state_next    = ret_reg;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (oidx_reg == LAST_DIGEST)
                    begin
                        cmd.msg_clear = 1'b1;
                        oidx_next     = '0;
                        state_next    = ST_IDLE;
                    end
                    else
                    begin
                        oidx_next = oidx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_last = (oidx_reg == LAST_DIGEST);

    // State and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            round_reg <= '0;
            mark_reg  <= 1'b0;
            oidx_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            round_reg <= round_next;
            mark_reg  <= mark_next;
            oidx_reg  <= oidx_next;
        end
    end

`ifndef SYNTH
    // Eighty rounds, then the chain update
    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == LAST_ROUND) |=> (state_reg == ST_FIN))
        else $error("round sequence did not finish into chain update");

    // Input and output sides never open together
    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open at once");

    // Length low word always closes the final block
    a_len_lo: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LEN_LO) |=> (state_reg == ST_ROUND && ret_reg == ST_OUT &&
                                      round_reg == '0))
        else $error("final block not started after length word");

    // Digest index stays within the five words
    a_oidx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (oidx_reg <= LAST_DIGEST))
        else $error("digest index out of range");
`endif

endmodule

[rtl/core/sha1_hash_engine_top.sv]
// SHA-1 hash engine top level: stream ports around controller and datapath.
//
// Hashes one message per run with standard SHA-1. Message words (big-endian,
// four bytes each) are taken one per cycle until sixteen have filled a block.
// The working variables load on the edge that takes the sixteenth word; the
// block then runs its 80 rounds on the single round unit and the chain
// update, during which s_tready is low. On the word marked tlast (0 to 4
// valid bytes) the engine pads the message one word per cycle, pausing while
// a block runs, runs one or two more blocks and then presents the five digest
// words H0..H4, the fifth with m_tlast set; no new word is taken until the
// fifth has been read out.
// Afterwards the chain value and byte count return to their initial values.
module sha1_hash_engine_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] data_word, [34:32] valid_bytes, [39:35] zero
    input  logic        s_tlast,    // last
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [31:0] digest_word
    output logic        m_tlast     // last_word
);
    import sha1_pkg::*;

    sha1_cmd_t    cmd;
    sha1_status_t status;

    sha1_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_last   (s_tlast),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_last  (m_tlast),
        .cmd       (cmd),
        .status    (status)
    );

    sha1_dpath u_dpath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .data_word   (s_tdata[31:0]),
        .valid_bytes (s_tdata[34:32]),
        .last        (s_tlast),
        .digest_word (m_tdata)
    );

endmodule

[test/sha1_hash_engine_top_test.sv]
// Self-checking stream testbench for the SHA-1 hash engine with its own digest predictor.
module sha1_hash_engine_top_test;

    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned HOLD_CYCLES    = 600;
    localparam int unsigned DRAIN_CYCLES   = 120;
    localparam int unsigned PHASE_WORDS    = 22;
    localparam int unsigned MAX_PRINTED    = 100;

    // SHA-1 initial chain value and round constants
    localparam logic [31:0] IV0 = 32'h6745_2301;
    localparam logic [31:0] IV1 = 32'hefcd_ab89;
    localparam logic [31:0] IV2 = 32'h98ba_dcfe;
    localparam logic [31:0] IV3 = 32'h1032_5476;
    localparam logic [31:0] IV4 = 32'hc3d2_e1f0;
    localparam logic [31:0] RK0 = 32'h5a82_7999;
    localparam logic [31:0] RK1 = 32'h6ed9_eba1;
    localparam logic [31:0] RK2 = 32'h8f1b_bcdc;
    localparam logic [31:0] RK3 = 32'hca62_c1d6;
    localparam logic [31:0] END_MARK = 32'h8000_0000;

    typedef struct {
        logic [31:0] data;
        logic [2:0]  nb;
        logic        last;
    } msg_word_t;

    typedef struct {
        logic [31:0] word;
        logic        last;
    } digest_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tlast;

    // Stimulus and expectation stores
    msg_word_t word_q[$];
    digest_t   digest_q[$];
    msg_word_t cur_word;
    int        words_queued = 0;
    int        words_accepted = 0;
    int        digests_seen = 0;
    int        errors = 0;

    // Idling controls, written at the falling edge only
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic recv_hold = 1'b0;

    // Predictor state
    logic [31:0] chain_h [5];
    logic [31:0] blk_w [16];
    logic [60:0] msg_bytes;

    sha1_hash_engine_top dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (errors < MAX_PRINTED)
        begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_chain();
        chain_h[0] = IV0;
        chain_h[1] = IV1;
        chain_h[2] = IV2;
        chain_h[3] = IV3;
        chain_h[4] = IV4;
        msg_bytes  = '0;
    endfunction

    // 80 rounds over the block buffer, folded into the chain value
    function automatic void sha1_compress();
        logic [31:0] sched [16];
        logic [31:0] a, b, c, d, e, f, k, w, t;
        sched = blk_w;
        a = chain_h[0];
        b = chain_h[1];
        c = chain_h[2];
        d = chain_h[3];
        e = chain_h[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 16)
            begin
                w = sched[r];
            end
            else
            begin
                w = rol32(sched[(r + 13) % 16] ^ sched[(r + 8) % 16] ^
                          sched[(r + 2) % 16] ^ sched[r % 16], 1);
                sched[r % 16] = w;
            end
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RK1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK3;
            end
            t = rol32(a, 5) + f + e + k + w;
            e = d;
            d = c;
            c = rol32(b, 30);
            b = a;
            a = t;
        end
        chain_h[0] += a;
        chain_h[1] += b;
        chain_h[2] += c;
        chain_h[3] += d;
        chain_h[4] += e;
    endfunction

    // Absorb one accepted word; on the final word pad, finish and queue the digest
    function automatic void hash_word(input msg_word_t mw);
        int          p;
        int          nbi;
        logic [31:0] word;
        logic [63:0] bitlen;
        digest_t     dg;
        p = int'(msg_bytes[5:2]);
        if (!mw.last)
        begin
            blk_w[p] = mw.data;
            msg_bytes = msg_bytes + 61'd4;
            if (p == 15)
            begin
                sha1_compress();
            end
        end
        else
        begin
            nbi = (mw.nb > 3'd4) ? 4 : int'(mw.nb);
            if (nbi == 0)
            begin
                word = END_MARK;
            end
            else if (nbi == 4)
            begin
                word = mw.data;
            end
            else
            begin
                word = (mw.data & (32'hffff_ffff << (32 - 8 * nbi))) |
                       (32'h80 << (24 - 8 * nbi));
            end
            msg_bytes = msg_bytes + 61'(nbi);
            blk_w[p] = word;
            p++;
            if (p == 16)
            begin
                sha1_compress();
                p = 0;
            end
            if (nbi == 4)
            begin
                blk_w[p] = END_MARK;
                p++;
                if (p == 16)
                begin
                    sha1_compress();
                    p = 0;
                end
            end
            // no room left for the length: pad out and run an extra block
            if (p > 14)
            begin
                while (p < 16)
                begin
                    blk_w[p] = '0;
                    p++;
                end
                sha1_compress();
                p = 0;
            end
            while (p < 14)
            begin
                blk_w[p] = '0;
                p++;
            end
            bitlen = {msg_bytes, 3'b000};
            blk_w[14] = bitlen[63:32];
            blk_w[15] = bitlen[31:0];
            sha1_compress();
            for (int i = 0; i < 5; i++)
            begin
                dg.word = chain_h[i];
                dg.last = (i == 4);
                digest_q.push_back(dg);
            end
            restart_chain();
        end
    endfunction

    function automatic void queue_word(input logic [31:0] data, input logic [2:0] nb,
                                       input logic last);
        msg_word_t mw;
        mw.data = data;
        mw.nb   = nb;
        mw.last = last;
        word_q.push_back(mw);
        words_queued++;
    endfunction

    // Mostly random data, now and then all zeros or all ones
    function automatic logic [31:0] pick_data();
        case ($urandom_range(9, 0))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // One message of full words and a final word; returns the number of words
    function automatic int queue_message(input int n_full);
        for (int i = 0; i < n_full; i++)
        begin
            queue_word(pick_data(), 3'($urandom_range(7, 0)), 1'b0);
        end
        queue_word(pick_data(), 3'($urandom_range(7, 0)), 1'b1);
        return n_full + 1;
    endfunction

    function automatic int pick_length();
        if ($urandom_range(7, 0) == 0)
        begin
            return $urandom_range(40, 19);
        end
        return $urandom_range(18, 0);
    endfunction

    task automatic wait_drained();
        while (words_accepted != words_queued || digest_q.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Driver: presents queued words, predicts each one as it is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                hash_word(cur_word);
                words_accepted++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (word_q.size() != 0 && $urandom_range(99, 0) >= send_idle_pct)
                begin
                    cur_word = word_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b00000, cur_word.nb, cur_word.data};
                    s_tlast  <= cur_word.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each digest word against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        digest_t exp_dg;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (digest_q.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected digest word %08h", m_tdata));
                end
                else
                begin
                    exp_dg = digest_q.pop_front();
                    if (m_tdata !== exp_dg.word)
                    begin
                        report_mismatch($sformatf("digest word %0d: got %08h, expected %08h",
                                                  digests_seen, m_tdata, exp_dg.word));
                    end
                    if (m_tlast !== exp_dg.last)
                    begin
                        report_mismatch($sformatf("digest word %0d: tlast %b, expected %b",
                                                  digests_seen, m_tlast, exp_dg.last));
                    end
                end
                digests_seen++;
            end
            m_tready <= !recv_hold && ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Stimulus sequence
    initial
    begin
        int n;
        int phase_words;
        restart_chain();
        for (int i = 0; i < 16; i++)
        begin
            blk_w[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, each valid byte count alone, two-block padding
        queue_word(32'hffff_ffff, 3'd0, 1'b1);
        for (n = 1; n < 8; n++)
        begin
            case (n % 3)
                0:       queue_word($urandom, 3'(n), 1'b1);
                1:       queue_word(32'h0000_0000, 3'(n), 1'b1);
                default: queue_word(32'hffff_ffff, 3'(n), 1'b1);
            endcase
        end
        void'(queue_message(13));
        for (n = 0; n < 13; n++)
        begin
            word_q[word_q.size() - 14 + n].data = $urandom;
        end
        word_q[word_q.size() - 1].nb = 3'd4;
        wait_drained();

        // Random messages under each idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 51;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 51;
                end
                default:
                begin
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
            endcase
            phase_words = 0;
            while (phase_words < PHASE_WORDS)
            begin
                phase_words += queue_message(pick_length());
            end
            wait_drained();
        end

        // Back-pressure: output held off while short messages keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold = 1'b1;
        fork
            begin
                repeat (HOLD_CYCLES) @(negedge clk);
                recv_hold = 1'b0;
            end
        join_none
        for (n = 0; n < 4; n++)
        begin
            void'(queue_message($urandom_range(3, 0)));
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0)
        begin
            $display("sha1_hash_engine_top_test: PASS");
        end
        else
        begin
            $display("sha1_hash_engine_top_test: FAIL");
        end
        $finish;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_CYCLES * 4);
        $display("sha1_hash_engine_top_test: FAIL");
        $finish;
    end

endmodule
